// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/tbgr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tbgr_pkg;

    // Field widths.
    localparam int DelayBits = 24;
    localparam int StepBits  = 16;
    localparam int StateBits = 4;
    localparam int CodeBits  = 4;
    localparam int EventBits = 3;
    localparam int EntryBits = 5;
    localparam int ApbAddrBits = 4;
    localparam int ApbDataBits = 32;

    // Register reset values.
    localparam logic [DelayBits-1:0] SHORT_DELAY_RST = 24'd500000;
    localparam logic [DelayBits-1:0] LONG_DELAY_RST  = 24'd9500000;
    localparam logic [StepBits-1:0]  TICK_STEP_RST   = 16'd100;

    // Register indexes (word address).
    localparam logic [1:0] REG_SHORT_DELAY = 2'd0;
    localparam logic [1:0] REG_LONG_DELAY  = 2'd1;
    localparam logic [1:0] REG_TICK_STEP   = 2'd2;

    // Request types.
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_BUTTON = 1'b1;

    // Machine states.
    localparam logic [StateBits-1:0] ST_IDLE        = 4'd0;
    localparam logic [StateBits-1:0] ST_B0_ON       = 4'd1;
    localparam logic [StateBits-1:0] ST_B1_ON       = 4'd2;
    localparam logic [StateBits-1:0] ST_B0_SHORT    = 4'd3;
    localparam logic [StateBits-1:0] ST_B1_SHORT    = 4'd4;
    localparam logic [StateBits-1:0] ST_BOTH        = 4'd5;
    localparam logic [StateBits-1:0] ST_BOTH_SHORT  = 4'd6;
    localparam logic [StateBits-1:0] ST_B0_ONOFF    = 4'd7;
    localparam logic [StateBits-1:0] ST_B1_ONOFF    = 4'd8;
    localparam logic [StateBits-1:0] ST_B0OFF_B1ON  = 4'd9;
    localparam logic [StateBits-1:0] ST_B1OFF_B0ON  = 4'd10;
    localparam logic [StateBits-1:0] ST_LAST        = ST_B1OFF_B0ON;

    // Gesture codes.
    localparam logic [CodeBits-1:0] G_TAP0      = 4'd0;
    localparam logic [CodeBits-1:0] G_TAP1      = 4'd1;
    localparam logic [CodeBits-1:0] G_PRESS0    = 4'd2;
    localparam logic [CodeBits-1:0] G_PRESS1    = 4'd3;
    localparam logic [CodeBits-1:0] G_LONG0     = 4'd4;
    localparam logic [CodeBits-1:0] G_LONG1     = 4'd5;
    localparam logic [CodeBits-1:0] G_BOTHTAP   = 4'd6;
    localparam logic [CodeBits-1:0] G_BOTHPRESS = 4'd7;
    localparam logic [CodeBits-1:0] G_BOTHLONG  = 4'd8;
    localparam logic [CodeBits-1:0] G_SLIDE01   = 4'd9;
    localparam logic [CodeBits-1:0] G_SLIDE10   = 4'd10;

    // Events fed to the machine.
    localparam logic [EventBits-1:0] EV_B0_ON  = 3'd0;
    localparam logic [EventBits-1:0] EV_B0_OFF = 3'd1;
    localparam logic [EventBits-1:0] EV_B1_ON  = 3'd2;
    localparam logic [EventBits-1:0] EV_B1_OFF = 3'd3;
    localparam logic [EventBits-1:0] EV_SHORT  = 3'd4;
    localparam logic [EventBits-1:0] EV_LONG   = 3'd5;

    // Table entry: top bit flags a gesture, all ones marks an invalid move.
    localparam logic [EntryBits-1:0] ENT_BAD = 5'b11111;

    typedef logic [EntryBits-1:0] t_entry;
    typedef logic [5:0][EntryBits-1:0] t_row;

    typedef struct packed {
        logic req_type;
        logic button_index;
        logic pressed;
    } t_in_item;

    typedef struct packed {
        logic                gesture_valid;
        logic [CodeBits-1:0] gesture_code;
        logic                fault;
        logic [StateBits-1:0] current_state;
    } t_out_item;

    typedef struct packed {
        logic [DelayBits-1:0] short_delay;
        logic [DelayBits-1:0] long_delay;
        logic [StepBits-1:0]  tick_step;
    } t_cfg;

    function automatic t_entry st(input logic [StateBits-1:0] s);
        return {1'b0, s};
    endfunction

    function automatic t_entry gs(input logic [CodeBits-1:0] c);
        return {1'b1, c};
    endfunction

    // Columns in event order: b0 on, b0 off, b1 on, b1 off, short, long.
    function automatic t_row mk_row(input t_entry e0, input t_entry e1, input t_entry e2,
                                    input t_entry e3, input t_entry e4, input t_entry e5);
        return {e5, e4, e3, e2, e1, e0};
    endfunction

    // Transition table lookup.
    function automatic t_entry next_entry(input logic [StateBits-1:0] s,
                                          input logic [EventBits-1:0] ev);
        t_row row;
        row = {6{ENT_BAD}};
        case (s)
            ST_IDLE: row = mk_row(st(ST_B0_ON), st(ST_IDLE), st(ST_B1_ON),
                                  st(ST_IDLE), st(ST_IDLE), st(ST_IDLE));
            ST_B0_ON: row = mk_row(st(ST_B0_ON), st(ST_B0_ONOFF), st(ST_BOTH),
                                   st(ST_B0_ON), st(ST_B0_SHORT), ENT_BAD);
            ST_B1_ON: row = mk_row(st(ST_BOTH), st(ST_B1_ON), st(ST_B1_ON),
                                   st(ST_B1_ONOFF), st(ST_B1_SHORT), ENT_BAD);
            ST_B0_SHORT: row = mk_row(st(ST_B0_SHORT), gs(G_PRESS0), st(ST_BOTH),
                                      st(ST_B0_SHORT), ENT_BAD, gs(G_LONG0));
            ST_B1_SHORT: row = mk_row(st(ST_BOTH), st(ST_B1_SHORT), st(ST_B1_SHORT),
                                      gs(G_PRESS1), ENT_BAD, gs(G_LONG1));
            ST_BOTH: row = mk_row(st(ST_BOTH), gs(G_BOTHTAP), st(ST_BOTH),
                                  gs(G_BOTHTAP), st(ST_BOTH_SHORT), ENT_BAD);
            ST_BOTH_SHORT: row = mk_row(st(ST_BOTH_SHORT), gs(G_BOTHPRESS),
                                        st(ST_BOTH_SHORT), gs(G_BOTHPRESS),
                                        ENT_BAD, gs(G_BOTHLONG));
            ST_B0_ONOFF: row = mk_row(st(ST_B0_ON), st(ST_B0_ONOFF), st(ST_B0OFF_B1ON),
                                      st(ST_B0_ONOFF), gs(G_TAP0), ENT_BAD);
            ST_B1_ONOFF: row = mk_row(st(ST_B1_ON), st(ST_B1_ONOFF), st(ST_B1OFF_B0ON),
                                      st(ST_B1_ONOFF), gs(G_TAP1), ENT_BAD);
            ST_B0OFF_B1ON: row = mk_row(st(ST_B0OFF_B1ON), st(ST_B0OFF_B1ON),
                                        st(ST_B0OFF_B1ON), gs(G_SLIDE01),
                                        gs(G_SLIDE01), ENT_BAD);
            ST_B1OFF_B0ON: row = mk_row(st(ST_B1OFF_B0ON), st(ST_B1OFF_B0ON),
                                        st(ST_B1OFF_B0ON), gs(G_SLIDE10),
                                        gs(G_SLIDE10), ENT_BAD);
            default: row = {6{ENT_BAD}};
        endcase
        if (ev > EV_LONG) begin
            return ENT_BAD;
        end
        return row[ev];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tbgr_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbgr_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tbgr_pkg::ApbAddrBits-1:0]     paddr,
    input  wire logic [tbgr_pkg::ApbDataBits-1:0]     pwdata,
    output logic      [tbgr_pkg::ApbDataBits-1:0]     prdata,
    output logic                                      pready,
    output tbgr_pkg::t_cfg                            o_cfg
);

    tbgr_pkg::t_cfg r_cfg;
    logic [1:0]     reg_index;
    logic           wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;

    // Register writes; an address beyond the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_delay <= tbgr_pkg::SHORT_DELAY_RST;
            r_cfg.long_delay  <= tbgr_pkg::LONG_DELAY_RST;
            r_cfg.tick_step   <= tbgr_pkg::TICK_STEP_RST;
        end else if (wr_en) begin
            case (reg_index)
                tbgr_pkg::REG_SHORT_DELAY: begin
                    r_cfg.short_delay <= pwdata[tbgr_pkg::DelayBits-1:0];
                end
                tbgr_pkg::REG_LONG_DELAY: begin
                    r_cfg.long_delay <= pwdata[tbgr_pkg::DelayBits-1:0];
                end
                tbgr_pkg::REG_TICK_STEP: begin
                    r_cfg.tick_step <= pwdata[tbgr_pkg::StepBits-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_index)
            tbgr_pkg::REG_SHORT_DELAY: begin
                prdata = tbgr_pkg::ApbDataBits'(r_cfg.short_delay);
            end
            tbgr_pkg::REG_LONG_DELAY: begin
                prdata = tbgr_pkg::ApbDataBits'(r_cfg.long_delay);
            end
            tbgr_pkg::REG_TICK_STEP: begin
                prdata = tbgr_pkg::ApbDataBits'(r_cfg.tick_step);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/tbgr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbgr_core #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire tbgr_pkg::t_in_item i_item,
    input  wire tbgr_pkg::t_cfg     i_cfg,
    output tbgr_pkg::t_out_item     o_result
);

    localparam int DelayBits = tbgr_pkg::DelayBits;
    localparam int StepBits  = tbgr_pkg::StepBits;
    localparam int CmpBits   = (COUNT_BITS > StepBits) ? COUNT_BITS : StepBits;

    logic [tbgr_pkg::StateBits-1:0] r_state, n_state;
    logic [COUNT_BITS-1:0]          r_count, n_count;
    logic                           r_run, n_run;
    logic                           r_long, n_long;

    logic [COUNT_BITS-1:0]          short_load;
    logic [COUNT_BITS-1:0]          long_load;
    logic [CmpBits-1:0]             count_ext;
    logic [CmpBits-1:0]             step_ext;
    logic [COUNT_BITS-1:0]          count_dec;
    logic                           is_button;
    logic                           expire;
    logic                           apply;
    logic [tbgr_pkg::EventBits-1:0] ev;
    tbgr_pkg::t_entry               entry;

    // Delay loads saturate to the largest count when the counter is narrower.
    generate
        if (COUNT_BITS >= DelayBits) begin : g_wide
            assign short_load = COUNT_BITS'(i_cfg.short_delay);
            assign long_load  = COUNT_BITS'(i_cfg.long_delay);
        end else begin : g_narrow
            assign short_load = (|i_cfg.short_delay[DelayBits-1:COUNT_BITS]) ?
                                '1 : i_cfg.short_delay[COUNT_BITS-1:0];
            assign long_load  = (|i_cfg.long_delay[DelayBits-1:COUNT_BITS]) ?
                                '1 : i_cfg.long_delay[COUNT_BITS-1:0];
        end
    endgenerate

    // Saturating countdown by the tick step.
    assign count_ext = CmpBits'(r_count);
    assign step_ext  = CmpBits'(i_cfg.tick_step);
    assign count_dec = (count_ext > step_ext) ? COUNT_BITS'(count_ext - step_ext) : '0;

    // Event selection: a button change, or an expiry on a tick at zero count.
    assign is_button = (i_item.req_type == tbgr_pkg::REQ_BUTTON);
    assign expire    = !is_button && r_run && (r_count == '0);
    assign apply     = is_button || expire;

    always_comb begin
        if (is_button) begin
            ev = {1'b0, i_item.button_index, ~i_item.pressed};
        end else if (r_long) begin
            ev = tbgr_pkg::EV_LONG;
        end else begin
            ev = tbgr_pkg::EV_SHORT;
        end
    end

    assign entry = tbgr_pkg::next_entry(r_state, ev);

    // Next state, timer and result for one item.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_run    = r_run;
        n_long   = r_long;
        o_result = '0;

        if (!is_button && r_run && (r_count != '0)) begin
            n_count = count_dec;
        end

        if (apply) begin
            if (expire) begin
                n_run = 1'b0;
            end
            if (entry == tbgr_pkg::ENT_BAD) begin
                n_state        = tbgr_pkg::ST_IDLE;
                n_run          = 1'b0;
                o_result.fault = 1'b1;
            end else if (entry[tbgr_pkg::EntryBits-1]) begin
                n_state                = tbgr_pkg::ST_IDLE;
                n_run                  = 1'b0;
                o_result.gesture_valid = 1'b1;
                o_result.gesture_code  = entry[tbgr_pkg::CodeBits-1:0];
            end else begin
                n_state = entry[tbgr_pkg::StateBits-1:0];
                if (n_state != tbgr_pkg::ST_IDLE) begin
                    if (ev == tbgr_pkg::EV_LONG) begin
                        n_run = 1'b0;
                    end else if (ev == tbgr_pkg::EV_SHORT) begin
                        n_count = long_load;
                        n_long  = 1'b1;
                        n_run   = 1'b1;
                    end else begin
                        n_count = short_load;
                        n_long  = 1'b0;
                        n_run   = 1'b1;
                    end
                end
            end
        end

        o_result.current_state = n_state;
    end

    // Machine and timer registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbgr_pkg::ST_IDLE;
            r_count <= '0;
            r_run   <= 1'b0;
            r_long  <= 1'b0;
        end else if (i_en) begin
            r_state <= n_state;
            r_count <= n_count;
            r_run   <= n_run;
            r_long  <= n_long;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/two_button_gesture_recognizer.sv -----
// Pipeline: an item passes the input register, then the result register.
// Throughput: one item per cycle while the receiver does not stall; the
// machine and timer update each time an item advances.
// Reset: synchronous, active low; machine idle, timer stopped at zero,
// registers at their default delays and step, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module two_button_gesture_recognizer #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire tbgr_pkg::t_in_item               i_in_item,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output tbgr_pkg::t_out_item                   o_out_item,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tbgr_pkg::ApbAddrBits-1:0] paddr,
    input  wire logic [tbgr_pkg::ApbDataBits-1:0] pwdata,
    output logic      [tbgr_pkg::ApbDataBits-1:0] prdata,
    output logic                                  pready
);

    tbgr_pkg::t_cfg      cfg;
    tbgr_pkg::t_in_item  r_in_item;
    logic                r_in_valid;
    tbgr_pkg::t_out_item r_out_item;
    logic                r_out_valid;
    tbgr_pkg::t_out_item result;
    logic                advance;
    logic                in_xfer;

    tbgr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tbgr_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // The held item moves on when the result register is free or being drained.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- hdl/tbgr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tbgr_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire tbgr_pkg::t_out_item  o_out_item
);

    // A gesture and a fault never come from the same transfer.
    `ASSERT_IMPLY(a_gesture_xor_fault, i_clk, !i_rst_n, o_out_valid,
        !(o_out_item.gesture_valid && o_out_item.fault))

    // The gesture code is zero unless a gesture is reported.
    `ASSERT_IMPLY(a_code_zero, i_clk, !i_rst_n,
        o_out_valid && !o_out_item.gesture_valid, o_out_item.gesture_code == 4'd0)

    // A completed gesture or a fault always leaves the machine idle.
    `ASSERT_IMPLY(a_end_idle, i_clk, !i_rst_n,
        o_out_valid && (o_out_item.gesture_valid || o_out_item.fault),
        o_out_item.current_state == tbgr_pkg::ST_IDLE)

    // The reported state never leaves the defined range.
    `ASSERT_IMPLY(a_state_range, i_clk, !i_rst_n, o_out_valid,
        o_out_item.current_state <= tbgr_pkg::ST_LAST)

    // A stalled result is held until it is transferred.
    `ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item))

endmodule

bind two_button_gesture_recognizer tbgr_checker u_tbgr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ----- tb/gesture_monitor.sv -----
`timescale 1ns / 1ps

module gesture_monitor (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_stall,
    input  tbgr_pkg::t_in_item                    i_in_item,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_stall,
    input  tbgr_pkg::t_out_item                   i_out_item,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tbgr_pkg::ApbAddrBits-1:0] paddr,
    input  wire logic [tbgr_pkg::ApbDataBits-1:0] pwdata,
    input  wire logic                             pready,
    output int                                    o_failures,
    output int                                    o_pending
);
    import tbgr_pkg::*;

    typedef enum logic [1:0] {MOVE_STATE, MOVE_GESTURE, MOVE_FAULT} t_move_kind;

    typedef struct packed {
        t_move_kind          kind;
        logic [StateBits-1:0] value;
    } t_move;

    // Shadow copy of the delay and step registers, taken from the bus.
    logic [DelayBits-1:0] short_load;
    logic [DelayBits-1:0] long_load;
    logic [StepBits-1:0]  step_size;

    // Machine and timer as the block should hold them.
    logic [StateBits-1:0] gest_state;
    logic [DelayBits-1:0] countdown;
    logic                 timer_on;
    logic                 long_pending;

    // Results owed by the block, oldest first.
    t_out_item gesture_q[$];

    function automatic t_move go_to(input logic [StateBits-1:0] s);
        t_move mv;
        mv.kind = MOVE_STATE;
        mv.value = s;
        return mv;
    endfunction

    function automatic t_move gesture_done(input logic [CodeBits-1:0] code);
        t_move mv;
        mv.kind = MOVE_GESTURE;
        mv.value = code;
        return mv;
    endfunction

    function automatic t_move invalid_move();
        t_move mv;
        mv.kind = MOVE_FAULT;
        mv.value = '0;
        return mv;
    endfunction

    // Where one event takes the machine; most events leave the state as it is.
    function automatic t_move lookup_move(input logic [StateBits-1:0] s,
                                          input logic [EventBits-1:0] ev);
        t_move mv;
        mv = go_to(s);
        case (s)
            ST_IDLE: begin
                case (ev)
                    EV_B0_ON: mv = go_to(ST_B0_ON);
                    EV_B1_ON: mv = go_to(ST_B1_ON);
                    default: mv = go_to(ST_IDLE);
                endcase
            end
            ST_B0_ON: begin
                case (ev)
                    EV_B0_OFF: mv = go_to(ST_B0_ONOFF);
                    EV_B1_ON: mv = go_to(ST_BOTH);
                    EV_SHORT: mv = go_to(ST_B0_SHORT);
                    EV_LONG: mv = invalid_move();
                    default: ;
                endcase
            end
            ST_B1_ON: begin
                case (ev)
                    EV_B0_ON: mv = go_to(ST_BOTH);
                    EV_B1_OFF: mv = go_to(ST_B1_ONOFF);
                    EV_SHORT: mv = go_to(ST_B1_SHORT);
                    EV_LONG: mv = invalid_move();
                    default: ;
                endcase
            end
            ST_B0_SHORT: begin
                case (ev)
                    EV_B0_OFF: mv = gesture_done(G_PRESS0);
                    EV_B1_ON: mv = go_to(ST_BOTH);
                    EV_SHORT: mv = invalid_move();
                    EV_LONG: mv = gesture_done(G_LONG0);
                    default: ;
                endcase
            end
            ST_B1_SHORT: begin
                // A release of button 0 keeps the state here.
                case (ev)
                    EV_B0_ON: mv = go_to(ST_BOTH);
                    EV_B1_OFF: mv = gesture_done(G_PRESS1);
                    EV_SHORT: mv = invalid_move();
                    EV_LONG: mv = gesture_done(G_LONG1);
                    default: ;
                endcase
            end
            ST_BOTH: begin
                case (ev)
                    EV_B0_OFF, EV_B1_OFF: mv = gesture_done(G_BOTHTAP);
                    EV_SHORT: mv = go_to(ST_BOTH_SHORT);
                    EV_LONG: mv = invalid_move();
                    default: ;
                endcase
            end
            ST_BOTH_SHORT: begin
                case (ev)
                    EV_B0_OFF, EV_B1_OFF: mv = gesture_done(G_BOTHPRESS);
                    EV_SHORT: mv = invalid_move();
                    EV_LONG: mv = gesture_done(G_BOTHLONG);
                    default: ;
                endcase
            end
            ST_B0_ONOFF: begin
                case (ev)
                    EV_B0_ON: mv = go_to(ST_B0_ON);
                    EV_B1_ON: mv = go_to(ST_B0OFF_B1ON);
                    EV_SHORT: mv = gesture_done(G_TAP0);
                    EV_LONG: mv = invalid_move();
                    default: ;
                endcase
            end
            ST_B1_ONOFF: begin
                case (ev)
                    EV_B0_ON: mv = go_to(ST_B1_ON);
                    EV_B1_ON: mv = go_to(ST_B1OFF_B0ON);
                    EV_SHORT: mv = gesture_done(G_TAP1);
                    EV_LONG: mv = invalid_move();
                    default: ;
                endcase
            end
            ST_B0OFF_B1ON: begin
                case (ev)
                    EV_B1_OFF, EV_SHORT: mv = gesture_done(G_SLIDE01);
                    EV_LONG: mv = invalid_move();
                    default: ;
                endcase
            end
            ST_B1OFF_B0ON: begin
                case (ev)
                    EV_B1_OFF, EV_SHORT: mv = gesture_done(G_SLIDE10);
                    EV_LONG: mv = invalid_move();
                    default: ;
                endcase
            end
            default: mv = invalid_move();
        endcase
        return mv;
    endfunction

    // Apply one event to the machine and update the timer behind it.
    task automatic feed_event(input logic [EventBits-1:0] ev, inout t_out_item res);
        t_move mv;
        mv = lookup_move(gest_state, ev);
        case (mv.kind)
            MOVE_FAULT: begin
                gest_state = ST_IDLE;
                timer_on = 1'b0;
                res.fault = 1'b1;
            end
            MOVE_GESTURE: begin
                res.gesture_valid = 1'b1;
                res.gesture_code = mv.value;
                gest_state = ST_IDLE;
                timer_on = 1'b0;
            end
            default: begin
                gest_state = mv.value;
                if (mv.value != ST_IDLE) begin
                    if (ev == EV_LONG) begin
                        timer_on = 1'b0;
                    end else if (ev == EV_SHORT) begin
                        countdown = long_load;
                        long_pending = 1'b1;
                        timer_on = 1'b1;
                    end else begin
                        countdown = short_load;
                        long_pending = 1'b0;
                        timer_on = 1'b1;
                    end
                end
            end
        endcase
    endtask

    // Work out the result of one input transfer.
    task automatic predict_gesture(input t_in_item item, output t_out_item res);
        res = '0;
        if (item.req_type == REQ_BUTTON) begin
            feed_event({1'b0, item.button_index, ~item.pressed}, res);
        end else if (timer_on) begin
            // The expiry comes on the tick after the count has reached zero.
            if (countdown == '0) begin
                timer_on = 1'b0;
                feed_event(long_pending ? EV_LONG : EV_SHORT, res);
            end else begin
                countdown = (countdown > step_size) ? countdown - step_size : '0;
            end
        end
        res.current_state = gest_state;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        o_failures++;
    endtask

    task automatic compare_field(input string name, input logic [3:0] got,
                                 input logic [3:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, %0h expected", name, got, want));
        end
    endtask

    // Watch the bus and both channels at every rising edge.
    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item res;
        if (!i_rst_n) begin
            short_load = SHORT_DELAY_RST;
            long_load = LONG_DELAY_RST;
            step_size = TICK_STEP_RST;
            gest_state = ST_IDLE;
            countdown = '0;
            timer_on = 1'b0;
            long_pending = 1'b0;
            gesture_q.delete();
            o_failures = 0;
        end else begin
            // Result transfer: compare with the oldest outstanding prediction.
            if (i_out_valid && !i_out_stall) begin
                if (gesture_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing outstanding",
                                              i_out_item));
                end else begin
                    want = gesture_q.pop_front();
                    compare_field("gesture_valid", 4'(i_out_item.gesture_valid),
                                  4'(want.gesture_valid));
                    compare_field("gesture_code", i_out_item.gesture_code,
                                  want.gesture_code);
                    compare_field("fault", 4'(i_out_item.fault), 4'(want.fault));
                    compare_field("current_state", i_out_item.current_state,
                                  want.current_state);
                end
            end
            // Register write; the unused fourth slot takes nothing.
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SHORT_DELAY: short_load = pwdata[DelayBits-1:0];
                    REG_LONG_DELAY: long_load = pwdata[DelayBits-1:0];
                    REG_TICK_STEP: step_size = pwdata[StepBits-1:0];
                    default: ;
                endcase
            end
            // Input transfer: predict and queue its result.
            if (i_in_valid && !i_in_stall) begin
                predict_gesture(i_in_item, res);
                gesture_q.push_back(res);
            end
        end
        o_pending = gesture_q.size();
    end

endmodule

// ----- tb/two_button_gesture_recognizer_tb.sv -----
`timescale 1ns / 1ps

module two_button_gesture_recognizer_tb;
    import tbgr_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int PhaseItems = 140;
    localparam int TimeoutNs = 2_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Input channel.
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;

    // Result channel.
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Register bus.
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ApbAddrBits-1:0] paddr = '0;
    logic [ApbDataBits-1:0] pwdata = '0;
    logic [ApbDataBits-1:0] prdata;
    logic                   pready;

    int failures;
    int pending;

    // Percentages for sender gaps, receiver stalls and ticks among items.
    int idle_pct = 0;
    int stall_pct = 0;
    int tick_pct = 60;

    // Buttons currently touched, so that most events are real touches and releases.
    logic [1:0] held = 2'b00;

    always #2 clk = ~clk;

    two_button_gesture_recognizer i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    gesture_monitor i_monitor (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .o_failures (failures),
        .o_pending  (pending)
    );

    // Receiver stalls at random at the configured rate.
    always @(negedge clk) begin
        out_stall = ($urandom_range(99) < stall_pct);
    end

    // Offer one item and hold it until the transfer takes place.
    task automatic send_item(input t_in_item item);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = item;
        do @(posedge clk); while (in_stall);
    endtask

    // Tick with random values in the fields that a tick ignores.
    task automatic send_tick();
        t_in_item item;
        item.req_type = REQ_TICK;
        item.button_index = 1'($urandom_range(1));
        item.pressed = 1'($urandom_range(1));
        send_item(item);
    endtask

    task automatic push_button(input logic idx, input logic down);
        t_in_item item;
        item.req_type = REQ_BUTTON;
        item.button_index = idx;
        item.pressed = down;
        held[idx] = down;
        send_item(item);
    endtask

    // Mostly real touches and releases; now and then a repeated or stray event.
    task automatic send_random();
        logic idx;
        idx = 1'($urandom_range(1));
        if ($urandom_range(99) < tick_pct) begin
            send_tick();
        end else if ($urandom_range(9) != 0) begin
            push_button(idx, !held[idx]);
        end else begin
            push_button(idx, 1'($urandom_range(1)));
        end
    endtask

    // Stop sending and let every outstanding result arrive.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [ApbDataBits-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(input logic [ApbDataBits-1:0] short_val,
                             input logic [ApbDataBits-1:0] long_val,
                             input logic [ApbDataBits-1:0] step_val);
        drain();
        write_reg(REG_SHORT_DELAY, short_val);
        write_reg(REG_LONG_DELAY, long_val);
        write_reg(REG_TICK_STEP, step_val);
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Default delays: a both-button tap, then events that idle ignores.
        push_button(1'b0, 1'b1);
        push_button(1'b1, 1'b1);
        push_button(1'b1, 1'b0);
        push_button(1'b0, 1'b0);
        send_tick();

        // Zero delays and the largest step, so each expiry takes one tick.
        configure(32'd0, 32'd0, 32'd65535);
        write_reg(REG_UNMAPPED, 32'd1);

        // Tap on button 0.
        push_button(1'b0, 1'b1);
        push_button(1'b0, 1'b0);
        send_tick();
        // Long hold on button 1, then a release that idle ignores.
        push_button(1'b1, 1'b1);
        send_tick();
        send_tick();
        push_button(1'b1, 1'b0);
        // A button event after the short window reloads the short delay, so the
        // next expiry is a short one where only a long one is allowed.
        push_button(1'b0, 1'b1);
        send_tick();
        push_button(1'b1, 1'b0);
        send_tick();
        // Slide from button 0 to button 1.
        push_button(1'b0, 1'b0);
        push_button(1'b0, 1'b1);
        push_button(1'b0, 1'b0);
        push_button(1'b1, 1'b1);
        push_button(1'b1, 1'b0);
        // Button 1 on, off, on: taken as a slide from 1 to 0 by the short expiry.
        push_button(1'b1, 1'b1);
        push_button(1'b1, 1'b0);
        push_button(1'b1, 1'b1);
        send_tick();
        push_button(1'b1, 1'b0);

        // Random phases, each with its own delays and one of four idling patterns.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: configure(32'd5, 32'd9, 32'd1);
                1: configure(32'd0, 32'd0, 32'd65535);
                2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: configure($urandom_range(20), $urandom_range(40), $urandom_range(8, 1));
                4: configure(32'd3, 32'd5, 32'd0);
                5: configure($urandom_range(20), $urandom_range(40), $urandom_range(8, 1));
                6: configure(32'd1, 32'd2, 32'd1);
                default: configure($urandom_range(1000), $urandom_range(2000),
                                   $urandom_range(300, 1));
            endcase
            case (p % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 80;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 80;
                end
                default: begin
                    idle_pct = 20;
                    stall_pct = 20;
                end
            endcase
            tick_pct = (p == 2) ? 80 : 60;
            repeat (PhaseItems) send_random();
        end

        drain();
        repeat (4) @(negedge clk);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Give up on a hung run.
    initial begin
        #(TimeoutNs);
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tbgr_pkg.sv
hdl/tbgr_regs.sv
hdl/tbgr_core.sv
hdl/two_button_gesture_recognizer.sv
hdl/tbgr_checker.sv
tb/gesture_monitor.sv
tb/two_button_gesture_recognizer_tb.sv
